FILE: rtl/core/cfdcrc_pkg.sv
// Shared types and constants for the CAN-FD payload CRC-16 checker.
// Holds the beat structs, the length XOR constants and the CRC byte update.
// No dependencies.
`timescale 1ns / 1ps

package cfdcrc_pkg;

    // Frame length limits; byte count saturates at the maximum.
    localparam int MAX_FRAME_BYTES = 64;
    localparam int LEN_W           = 7;

    // CRC-16 polynomial (x^16 + x^12 + x^5 + 1), MSB first.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Supported frame lengths and their final XOR masks.
    localparam logic [LEN_W-1:0] LEN_8  = LEN_W'(8);
    localparam logic [LEN_W-1:0] LEN_16 = LEN_W'(16);
    localparam logic [LEN_W-1:0] LEN_24 = LEN_W'(24);
    localparam logic [LEN_W-1:0] LEN_32 = LEN_W'(32);

    localparam logic [15:0] XOR_LEN_8  = 16'h5F29;
    localparam logic [15:0] XOR_LEN_16 = 16'h041D;
    localparam logic [15:0] XOR_LEN_24 = 16'h819D;
    localparam logic [15:0] XOR_LEN_32 = 16'h9F5B;

    // Status codes.
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_UNSUPPORTED = 1'b1;

    // Input beat: one payload byte.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] frame_address;
        logic        last_byte;
    } in_t;

    // Output beat: one result per frame.
    typedef struct packed {
        logic [15:0]      checksum_value;
        logic             checksum_match;
        logic             status;
        logic [LEN_W-1:0] frame_length;
    } out_t;

    // Advance the CRC by one byte, MSB first. The loop is a fixed XOR network.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/canfd_payload_crc16_checker.sv
// Top level of the CAN-FD payload CRC-16 checker.
// Depends on cfdcrc_pkg for beat types, constants and the CRC byte update.
`timescale 1ns / 1ps

// Usage:
// Payload bytes of a frame enter on the input channel (in_valid, in_ready,
// in_data), one byte per beat, in order, with last_byte set on the final
// byte. Bytes 0 and 1 are the received checksum, little-endian; the rest
// feed the CRC. frame_address is sampled only on the last byte.
// One result beat leaves on the output channel (out_valid, out_ready,
// out_data) per frame: the computed checksum, the match flag, the status
// and the saturated byte count. Non-last bytes produce no output beat.
// An accepted byte goes into the input register, then through the
// byte-wide CRC update and length decode into the output register.
// Throughput is one byte per cycle while no last byte waits on a full
// output register, set by the single byte-wide CRC step that updates
// the running CRC each cycle.
// When the receiver stalls with a result pending, non-last bytes of the
// next frame keep flowing; only a second last byte waits in the input
// register, and in_ready drops until the output register frees.
// Reset clears the running CRC, byte count, received checksum and both
// valid flags; no beat is pending afterwards.
module canfd_payload_crc16_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cfdcrc_pkg::in_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cfdcrc_pkg::out_t  out_data
);

    localparam int LW = cfdcrc_pkg::LEN_W;

    // Input register.
    logic             in_vld_reg;
    cfdcrc_pkg::in_t  in_beat_reg;

    // Frame state.
    logic [15:0]   crc_reg,   crc_next;
    logic [LW-1:0] cnt_reg,   cnt_next;
    logic [15:0]   rcv_reg,   rcv_next;

    // Output register.
    logic              out_vld_reg;
    cfdcrc_pkg::out_t  out_beat_reg, out_beat_next;

    logic advance;

    // A held beat moves on unless it is a last byte blocked by a full output.
    assign advance  = in_vld_reg &&
                      (!in_beat_reg.last_byte || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // Per-byte processing and the end-of-frame result.
    always_comb
    begin
        logic [15:0]   crc_cur;
        logic [15:0]   crc_fin;
        logic [15:0]   xr;
        logic          len_ok;
        logic [LW-1:0] cnt_inc;

        rcv_next = rcv_reg;
        crc_cur  = crc_reg;
        if (cnt_reg == LW'(0))
        begin
            rcv_next = {rcv_reg[15:8], in_beat_reg.data_byte};
        end
        else if (cnt_reg == LW'(1))
        begin
            rcv_next = {in_beat_reg.data_byte, rcv_reg[7:0]};
        end
        else
        begin
            crc_cur = cfdcrc_pkg::crc_feed(crc_reg, in_beat_reg.data_byte);
        end

        if (cnt_reg < LW'(cfdcrc_pkg::MAX_FRAME_BYTES))
        begin
            cnt_inc = cnt_reg + LW'(1);
        end
        else
        begin
            cnt_inc = cnt_reg;
        end

        // Fold in the frame address, low byte first.
        crc_fin = cfdcrc_pkg::crc_feed(crc_cur, in_beat_reg.frame_address[7:0]);
        crc_fin = cfdcrc_pkg::crc_feed(crc_fin, in_beat_reg.frame_address[15:8]);

        // Length decode picks the XOR mask.
        len_ok = 1'b1;
        unique case (cnt_inc)
            cfdcrc_pkg::LEN_8:  xr = cfdcrc_pkg::XOR_LEN_8;
            cfdcrc_pkg::LEN_16: xr = cfdcrc_pkg::XOR_LEN_16;
            cfdcrc_pkg::LEN_24: xr = cfdcrc_pkg::XOR_LEN_24;
            cfdcrc_pkg::LEN_32: xr = cfdcrc_pkg::XOR_LEN_32;
            default:
            begin
                xr     = 16'h0000;
                len_ok = 1'b0;
            end
        endcase

        out_beat_next.frame_length = cnt_inc;
        if (len_ok)
        begin
            out_beat_next.checksum_value = crc_fin ^ xr;
            out_beat_next.checksum_match = (rcv_next == (crc_fin ^ xr));
            out_beat_next.status         = cfdcrc_pkg::STATUS_OK;
        end
        else
        begin
            out_beat_next.checksum_value = 16'h0000;
            out_beat_next.checksum_match = 1'b0;
            out_beat_next.status         = cfdcrc_pkg::STATUS_UNSUPPORTED;
        end

        // Frame state clears after the last byte.
        if (in_beat_reg.last_byte)
        begin
            crc_next = 16'h0000;
            cnt_next = '0;
            rcv_next = 16'h0000;
        end
        else
        begin
            crc_next = crc_cur;
            cnt_next = cnt_inc;
        end
    end

    // Control and frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            crc_reg     <= 16'h0000;
            cnt_reg     <= '0;
            rcv_reg     <= 16'h0000;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                crc_reg <= crc_next;
                cnt_reg <= cnt_next;
                rcv_reg <= rcv_next;
            end
            if (advance && in_beat_reg.last_byte)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_beat_reg <= in_data;
        end
        if (advance && in_beat_reg.last_byte)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_beat_reg;

endmodule
